// ----- sv/hsv_pkg.sv -----
// Shared types, constants and hue-wheel helpers for the HSV to RGB converter.
package hsv_pkg;

  localparam int unsigned HueW  = 11;
  localparam int unsigned ChanW = 8;
  localparam int unsigned PixW  = 16;

  typedef logic [HueW-1:0]  hue_t;
  typedef logic [ChanW-1:0] chan_t;
  typedef logic [PixW-1:0]  pix_t;
  typedef logic [2:0]       sector_t;

  localparam hue_t  HueWrap = 11'd1536;
  localparam chan_t Full    = 8'hFF;

  // Sector offsets that correspond to hue offsets of 1024 and 512.
  localparam sector_t GreenShift = 3'd4;
  localparam sector_t BlueShift  = 3'd2;
  localparam sector_t NumSectors = 3'd6;

  // Rotates a sector index around the six-sector wheel.
  function automatic sector_t sector_add(sector_t sec, sector_t shift);
    logic [3:0] sum;
    sum = {1'b0, sec} + {1'b0, shift};
    if (sum >= {1'b0, NumSectors}) begin
      sum = sum - {1'b0, NumSectors};
    end
    return sum[2:0];
  endfunction

  // Full-saturation, full-brightness level of one channel.
  function automatic chan_t bump_level(sector_t sec, chan_t lsb);
    chan_t lvl;
    case (sec)
      3'd0:    lvl = Full;
      3'd1:    lvl = Full - lsb;
      3'd2:    lvl = '0;
      3'd3:    lvl = '0;
      3'd4:    lvl = lsb;
      default: lvl = Full;
    endcase
    return lvl;
  endfunction

  function automatic pix_t pack_565(chan_t r, chan_t g, chan_t b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

// ----- sv/hsv_to_rgb_converter_top.sv -----
// Three-stage pipelined HSV to RGB888 and RGB565 converter.
// Items pass through three register stages: stage one, stage two and the output registers.
// Throughput: one item per clock while out_stall is low; the three 8x8 channel multipliers in
// stage two and the saturation-times-value multiplier in stage one set the stage depth.
// A stalled output holds its item, and in_stall rises only when every stage is full.
// Synchronous reset clears all valid bits; data registers are not reset.
module hsv_to_rgb_converter_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  hsv_pkg::hue_t  hue,
  input  hsv_pkg::chan_t saturation,
  input  hsv_pkg::chan_t brightness,
  output logic           out_valid,
  input  logic           out_stall,
  output hsv_pkg::chan_t red,
  output hsv_pkg::chan_t green,
  output hsv_pkg::chan_t blue,
  output hsv_pkg::pix_t  pixel_565
);
  import hsv_pkg::*;

  logic v1, v2;
  logic en1, en2, en3;

  // Stage one: wheel position, bump levels and c = (s*v)>>8.
  chan_t bump_r1, bump_g1, bump_b1, c1, val1;
  // Stage two: scaled bumps and d = v - c.
  chan_t pr2, pg2, pb2, d2;

  hue_t    h_wrap;
  sector_t sec;
  logic [2*ChanW-1:0] sv_prod;
  logic [2*ChanW-1:0] r_prod, g_prod, b_prod;
  chan_t r3, g3, b3;

  assign en3 = !out_valid || !out_stall;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_stall = !en1;

  always_comb begin
    h_wrap = (hue >= HueWrap) ? hue - HueWrap : hue;
    sec = h_wrap[10:8];
    sv_prod = saturation * brightness;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
    if (en1 && in_valid) begin
      bump_r1 <= bump_level(sec, h_wrap[7:0]);
      bump_g1 <= bump_level(sector_add(sec, GreenShift), h_wrap[7:0]);
      bump_b1 <= bump_level(sector_add(sec, BlueShift), h_wrap[7:0]);
      c1      <= sv_prod[15:8];
      val1    <= brightness;
    end
  end

  always_comb begin
    r_prod = bump_r1 * c1;
    g_prod = bump_g1 * c1;
    b_prod = bump_b1 * c1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2 && v1) begin
      pr2 <= r_prod[15:8];
      pg2 <= g_prod[15:8];
      pb2 <= b_prod[15:8];
      d2  <= val1 - c1;
    end
  end

  // The scaled bump never exceeds c, so adding d stays within brightness.
  always_comb begin
    r3 = pr2 + d2;
    g3 = pg2 + d2;
    b3 = pb2 + d2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en3) begin
      out_valid <= v2;
    end
    if (en3 && v2) begin
      red       <= r3;
      green     <= g3;
      blue      <= b3;
      pixel_565 <= pack_565(r3, g3, b3);
    end
  end

endmodule

// ----- sv/hsv_checker.sv -----
// Port-level checker for the HSV converter, bound to the top level.
module hsv_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input hsv_pkg::chan_t red,
  input hsv_pkg::chan_t green,
  input hsv_pkg::chan_t blue,
  input hsv_pkg::pix_t  pixel_565
);
  import hsv_pkg::*;

  // While out_valid is high, the packed pixel agrees with the three channels.
  a_pack: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pixel_565 == pack_565(red, green, blue))
    else $error("pixel_565 does not match red, green and blue");

  // The input side backs up only when a finished item is held at the output.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output is free");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // A stalled result stays in place.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(red) && $stable(green)
                                  && $stable(blue) && $stable(pixel_565)))
    else $error("stalled result changed");

endmodule

bind hsv_to_rgb_converter_top hsv_checker u_hsv_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .red       (red),
  .green     (green),
  .blue      (blue),
  .pixel_565 (pixel_565)
);
